@@ sv/cidat_pkg.sv @@
// Package for the CAN ID activity table: record layout and fixed constants.
// Depends on nothing; used by can_id_activity_table.
package cidat_pkg;

    // Request codes.
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // Largest data length code of a classic CAN frame.
    localparam logic [3:0] MAX_DLC = 4'd8;

    // Saturation limits.
    localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] U16_MAX = 16'hFFFF;

    // One activity record as held in the record memory.
    typedef struct packed {
        logic        present;
        logic [3:0]  length;
        logic [63:0] payload;
        logic [63:0] last_arrival;
        logic [63:0] prev_arrival;
        logic [63:0] change_time;
        logic [31:0] count;
        logic [31:0] delta;
        logic [31:0] period;
        logic [31:0] jitter;
        logic [15:0] score;
    } t_rec;

    // Change times of the eight payload bytes of one record.
    typedef logic [7:0][63:0] t_byte_times;

endpackage

@@ sv/can_id_activity_table.sv @@
// CAN ID activity table: one activity record per channel and standard ID.
// Depends on cidat_pkg for the record layout and constants.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  request  | in        | i_valid / o_ready  | req_type, channel, frame_id, ...
//  result   | out       | o_valid / i_ready  | dropped, seen, ..., byte_change_time
//
// An update passes through the read, compare (S_RD), period (S_PER) and write-back
// (S_WB) steps; a read skips the period step and a dropped update goes straight to
// write-back. o_valid is registered when write-back completes, and o_ready returns
// in the same cycle that o_valid rises. After reset a clearing pass zeroes both memories,
// one record per cycle over all CHANNEL_COUNT*ID_COUNT records, with o_ready low. A
// stalled result holds the write-back state.
module can_id_activity_table #(
    parameter int ID_COUNT      = 2048,
    parameter int CHANNEL_COUNT = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_channel,
    input  logic [28:0] i_frame_id,
    input  logic [3:0]  i_length_code,
    input  logic [63:0] i_payload,
    input  logic [63:0] i_timestamp_us,
    input  logic [2:0]  i_byte_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_dropped,
    output logic        o_seen,
    output logic [3:0]  o_stored_length,
    output logic [63:0] o_stored_payload,
    output logic [31:0] o_frame_count,
    output logic [63:0] o_last_arrival,
    output logic [31:0] o_arrival_delta,
    output logic [31:0] o_period_estimate,
    output logic [31:0] o_gap_jitter,
    output logic [63:0] o_last_change_time,
    output logic [15:0] o_activity_score,
    output logic [63:0] o_byte_change_time
);
    import cidat_pkg::*;

    localparam int REC_COUNT = CHANNEL_COUNT * ID_COUNT;
    localparam int ADDR_W    = (REC_COUNT > 1) ? $clog2(REC_COUNT) : 1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_PER  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    // Memories.
    t_rec        r_rec_mem  [REC_COUNT];
    t_byte_times r_byte_mem [REC_COUNT];

    logic [2:0]        r_state;
    logic [ADDR_W-1:0] r_clr;
    logic              r_req, r_drop, r_was;
    logic [2:0]        r_bi;
    logic [3:0]        r_dlc;
    logic [63:0]       r_pl, r_ts;
    logic [ADDR_W-1:0] r_addr;
    t_rec              r_rec, r_new;
    t_byte_times       r_bct, r_newb;

    logic              accept, out_free, wb_fire, mem_we;
    logic [ADDR_W-1:0] slot, mem_wa;
    t_rec              mem_wd;
    t_byte_times       mem_wdb;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !o_valid || i_ready;
    assign wb_fire  = (r_state == S_WB) && out_free;

    // Record address: out-of-range channel and ID fall back to zero.
    always_comb begin
        logic [ADDR_W-1:0] c, id;
        c  = (i_channel < 8'(CHANNEL_COUNT)) ? ADDR_W'(i_channel) : '0;
        id = (i_frame_id < 29'(ID_COUNT)) ? ADDR_W'(i_frame_id) : '0;
        slot = ADDR_W'(c * ADDR_W'(ID_COUNT)) + id;
    end

    // Memory write port: clearing pass or record write-back.
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_addr;
        mem_wd  = r_new;
        mem_wdb = r_newb;
        if (r_state == S_CLR) begin
            mem_we  = 1'b1;
            mem_wa  = r_clr;
            mem_wd  = '0;
            mem_wdb = '0;
        end else if (wb_fire && !r_drop && r_req == REQ_UPDATE) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rec_mem[mem_wa]  <= mem_wd;
            r_byte_mem[mem_wa] <= mem_wdb;
        end
        if (accept) begin
            r_rec <= r_rec_mem[slot];
            r_bct <= r_byte_mem[slot];
        end
    end

    // Control sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    if (r_clr == ADDR_W'(REC_COUNT - 1)) r_state <= S_IDLE;
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_req_type == REQ_UPDATE && i_frame_id >= 29'(ID_COUNT))
                            r_state <= S_WB;
                        else
                            r_state <= S_RD;
                    end
                end
                S_RD:  r_state <= (r_req == REQ_UPDATE) ? S_PER : S_WB;
                S_PER: r_state <= S_WB;
                S_WB: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_CLR;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_req_type;
            r_drop <= (i_req_type == REQ_UPDATE) && (i_frame_id >= 29'(ID_COUNT));
            r_bi   <= i_byte_index;
            r_dlc  <= (i_length_code > MAX_DLC) ? MAX_DLC : i_length_code;
            r_pl   <= i_payload;
            r_ts   <= i_timestamp_us;
            r_addr <= slot;
        end
    end

    // Record update: byte compare and gap in the read stage, period and the
    // written jitter next.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            logic        chg;
            logic [63:0] d64;
            t_rec        nr;
            t_byte_times nb;
            nr  = r_rec;
            nb  = r_bct;
            chg = !r_rec.present;
            if (r_req == REQ_UPDATE) begin
                for (int i = 0; i < 8; i++) begin
                    if (4'(i) < r_dlc) begin
                        if (!r_rec.present || r_rec.payload[8*i +: 8] != r_pl[8*i +: 8]) begin
                            nb[i] = r_ts;
                            chg   = 1'b1;
                        end
                        nr.payload[8*i +: 8] = r_pl[8*i +: 8];
                    end
                end
                nr.prev_arrival = r_rec.present ? r_rec.last_arrival : r_ts;
                nr.last_arrival = r_ts;
                nr.length       = r_dlc;
                nr.count        = r_rec.count + 32'd1;
                if (r_rec.present) begin
                    d64      = r_ts - r_rec.last_arrival;
                    nr.delta = (d64[63:32] != '0) ? U32_MAX : d64[31:0];
                end
                if (chg) begin
                    nr.change_time = r_ts;
                    if (r_rec.score != U16_MAX) nr.score = r_rec.score + 16'd1;
                end
                nr.present = 1'b1;
            end
            r_new  <= nr;
            r_newb <= nb;
            r_was  <= r_rec.present;
        end else if (r_state == S_PER) begin
            logic [31:0] p;
            logic [34:0] acc;
            acc = ({3'b000, r_new.period} << 3) - {3'b000, r_new.period}
                  + {3'b000, r_new.delta};
            p = (r_new.period == '0) ? r_new.delta : acc[34:3];
            if (r_was) begin
                r_new.period <= p;
                r_new.jitter <= (r_new.delta > p) ? r_new.delta - p : p - r_new.delta;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            if (wb_fire) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_fire) begin
            logic [31:0] jit;
            jit = r_new.jitter;
            if (r_req == REQ_UPDATE && r_was)
                jit = (r_new.delta > r_new.period) ? r_new.delta - r_new.period
                                                   : r_new.period - r_new.delta;
            if (r_drop) begin
                o_dropped          <= 1'b1;
                o_seen             <= 1'b0;
                o_stored_length    <= '0;
                o_stored_payload   <= '0;
                o_frame_count      <= '0;
                o_last_arrival     <= '0;
                o_arrival_delta    <= '0;
                o_period_estimate  <= '0;
                o_gap_jitter       <= '0;
                o_last_change_time <= '0;
                o_activity_score   <= '0;
                o_byte_change_time <= '0;
            end else begin
                o_dropped          <= 1'b0;
                o_seen             <= r_new.present;
                o_stored_length    <= r_new.length;
                o_stored_payload   <= r_new.payload;
                o_frame_count      <= r_new.count;
                o_last_arrival     <= r_new.last_arrival;
                o_arrival_delta    <= r_new.delta;
                o_period_estimate  <= r_new.period;
                o_gap_jitter       <= jit;
                o_last_change_time <= r_new.change_time;
                o_activity_score   <= r_new.score;
                o_byte_change_time <= r_newb[r_bi];
            end
        end
    end

    // A dropped result carries nothing but the drop flag.
    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dropped |-> !o_seen && o_frame_count == '0)
        else $error("dropped result carries record data");

    // No request is taken while the clearing pass runs.
    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !o_ready)
        else $error("request accepted during clearing");

    // An applied update always reports a present record.
    a_update_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wb_fire && !r_drop && r_req == REQ_UPDATE |=> o_seen)
        else $error("update result not marked seen");

    // The memory is written only from the clearing pass or write-back.
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state == S_CLR || r_state == S_WB)
        else $error("unexpected memory write");

endmodule

@@ test/can_id_activity_table_tb.sv @@
// Testbench for can_id_activity_table: directed and random frame updates and reads.
// Depends on cidat_pkg and the can_id_activity_table RTL; a scoreboard class predicts results.
`timescale 1ns / 100ps

module can_id_activity_table_tb;
    import cidat_pkg::*;

    localparam int IDS        = 2048;
    localparam int CHANS      = 2;
    localparam int RECS       = IDS * CHANS;
    localparam int RAND_ITEMS = 1250;
    localparam int LIMIT      = 400000;
    localparam int DRAIN      = 20;

    typedef struct {
        logic        req_type;
        logic [7:0]  channel;
        logic [28:0] frame_id;
        logic [3:0]  length_code;
        logic [63:0] payload;
        logic [63:0] timestamp_us;
        logic [2:0]  byte_index;
    } t_request;

    typedef struct {
        logic        dropped;
        logic        seen;
        logic [3:0]  stored_length;
        logic [63:0] stored_payload;
        logic [31:0] frame_count;
        logic [63:0] last_arrival;
        logic [31:0] arrival_delta;
        logic [31:0] period_estimate;
        logic [31:0] gap_jitter;
        logic [63:0] last_change_time;
        logic [15:0] activity_score;
        logic [63:0] byte_change_time;
    } t_record_view;

    // Scoreboard: holds its own copy of the record table and the pending results.
    class activity_scoreboard;
        bit          present[RECS];
        bit [3:0]    length[RECS];
        bit [63:0]   payload[RECS];
        bit [63:0]   byte_time[RECS*8];
        bit [63:0]   last_arr[RECS];
        bit [63:0]   prev_arr[RECS];
        bit [63:0]   change_time[RECS];
        bit [31:0]   count[RECS];
        bit [31:0]   delta[RECS];
        bit [31:0]   period[RECS];
        bit [31:0]   jitter[RECS];
        bit [15:0]   score[RECS];
        t_record_view pending[$];
        int          errors;
        int          updates;
        int          reads;
        int          drops;
        int          results;

        // Apply one accepted transaction to the table and queue its expected result.
        function void note_request(t_request r);
            t_record_view v;
            int          rec;
            int          dlc;
            bit          was;
            bit          changed;
            bit [63:0]   mask;
            bit [63:0]   gap64;
            bit [31:0]   gap;
            bit [63:0]   avg;
            v = '{default: '0};
            if (r.req_type == REQ_UPDATE && r.frame_id >= IDS) begin
                v.dropped = 1'b1;
                drops++;
                pending.push_back(v);
                return;
            end
            rec = ((r.channel < CHANS) ? int'(r.channel) : 0) * IDS
                + ((r.frame_id < IDS) ? int'(r.frame_id) : 0);
            if (r.req_type == REQ_UPDATE) begin
                updates++;
                dlc = (r.length_code > MAX_DLC) ? int'(MAX_DLC) : int'(r.length_code);
                was = present[rec];
                changed = !was;
                for (int b = 0; b < dlc; b++) begin
                    mask = 64'hFF << (8 * b);
                    if (!was || ((payload[rec] ^ r.payload) & mask) != 0) begin
                        byte_time[rec*8 + b] = r.timestamp_us;
                        changed = 1'b1;
                    end
                    payload[rec] = (payload[rec] & ~mask) | (r.payload & mask);
                end
                prev_arr[rec] = was ? last_arr[rec] : r.timestamp_us;
                last_arr[rec] = r.timestamp_us;
                length[rec] = dlc[3:0];
                count[rec] = count[rec] + 1;
                if (was) begin
                    // The 64-bit gap wraps when time runs backwards, then saturates.
                    gap64 = r.timestamp_us - prev_arr[rec];
                    gap = (gap64 > 64'hFFFF_FFFF) ? U32_MAX : gap64[31:0];
                    delta[rec] = gap;
                    if (period[rec] == 0) begin
                        period[rec] = gap;
                    end else begin
                        avg = ({32'd0, period[rec]} * 7 + {32'd0, gap}) / 8;
                        period[rec] = avg[31:0];
                    end
                    jitter[rec] = (gap > period[rec]) ? gap - period[rec] : period[rec] - gap;
                end
                if (changed) begin
                    change_time[rec] = r.timestamp_us;
                    if (score[rec] != U16_MAX) score[rec] = score[rec] + 1;
                end
                present[rec] = 1'b1;
            end else begin
                reads++;
            end
            v.seen             = present[rec];
            v.stored_length    = length[rec];
            v.stored_payload   = payload[rec];
            v.frame_count      = count[rec];
            v.last_arrival     = last_arr[rec];
            v.arrival_delta    = delta[rec];
            v.period_estimate  = period[rec];
            v.gap_jitter       = jitter[rec];
            v.last_change_time = change_time[rec];
            v.activity_score   = score[rec];
            v.byte_change_time = byte_time[rec*8 + r.byte_index];
            pending.push_back(v);
        endfunction

        function void field(string name, logic [63:0] exp, logic [63:0] act);
            if (exp !== act) begin
                $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp, act);
                errors++;
            end
        endfunction

        // Compare one accepted result transaction with the oldest expectation.
        function void check_result(t_record_view a);
            t_record_view e;
            results++;
            if (pending.size() == 0) begin
                $display("%0t: result transaction with nothing expected", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            field("dropped", e.dropped, a.dropped);
            field("seen", e.seen, a.seen);
            field("stored_length", e.stored_length, a.stored_length);
            field("stored_payload", e.stored_payload, a.stored_payload);
            field("frame_count", e.frame_count, a.frame_count);
            field("last_arrival", e.last_arrival, a.last_arrival);
            field("arrival_delta", e.arrival_delta, a.arrival_delta);
            field("period_estimate", e.period_estimate, a.period_estimate);
            field("gap_jitter", e.gap_jitter, a.gap_jitter);
            field("last_change_time", e.last_change_time, a.last_change_time);
            field("activity_score", e.activity_score, a.activity_score);
            field("byte_change_time", e.byte_change_time, a.byte_change_time);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_req_type = 1'b0;
    logic [7:0]  i_channel = '0;
    logic [28:0] i_frame_id = '0;
    logic [3:0]  i_length_code = '0;
    logic [63:0] i_payload = '0;
    logic [63:0] i_timestamp_us = '0;
    logic [2:0]  i_byte_index = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_dropped;
    logic        o_seen;
    logic [3:0]  o_stored_length;
    logic [63:0] o_stored_payload;
    logic [31:0] o_frame_count;
    logic [63:0] o_last_arrival;
    logic [31:0] o_arrival_delta;
    logic [31:0] o_period_estimate;
    logic [31:0] o_gap_jitter;
    logic [63:0] o_last_change_time;
    logic [15:0] o_activity_score;
    logic [63:0] o_byte_change_time;

    activity_scoreboard sb = new();
    int          cycles = 0;
    bit          hold_done = 1'b0;
    logic [63:0] now_us = 64'd1000;
    logic [63:0] last_pay[16];
    logic [28:0] id_pool[16] = '{0, 1, 2, 3, 7, 100, 255, 1023, 1024, 2046, 2047,
                                 12, 500, 777, 1500, 2000};

    can_id_activity_table #(.ID_COUNT(IDS), .CHANNEL_COUNT(CHANS)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: sample at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result('{o_dropped, o_seen, o_stored_length, o_stored_payload,
                              o_frame_count, o_last_arrival, o_arrival_delta,
                              o_period_estimate, o_gap_jitter, o_last_change_time,
                              o_activity_score, o_byte_change_time});
        end
    end

    // Receiver stall pattern: phases of full rate, random stalls and one long hold-off.
    initial begin
        int phase_left;
        int mode;
        phase_left = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && sb.results >= 300) begin
                hold_done = 1'b1;
                i_ready = 1'b0;
                repeat (300) @(negedge i_clk);
            end
            if (phase_left == 0) begin
                mode = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 150);
            end
            phase_left--;
            case (mode)
                0: i_ready = 1'b1;
                1: i_ready = ($urandom_range(0, 1) == 1);
                default: i_ready = ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Offer one request and hold it until accepted; the caller decides what follows.
    task automatic send_request(t_request r);
        i_valid        = 1'b1;
        i_req_type     = r.req_type;
        i_channel      = r.channel;
        i_frame_id     = r.frame_id;
        i_length_code  = r.length_code;
        i_payload      = r.payload;
        i_timestamp_us = r.timestamp_us;
        i_byte_index   = r.byte_index;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic idle_for(int n);
        i_valid = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // Mostly updates on a small set of records with a moving clock, plus reads and noise.
    function automatic t_request random_request();
        t_request r;
        int       sel;
        int       k;
        logic [63:0] flip;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, 15);
        r.req_type     = REQ_UPDATE;
        r.channel      = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
        r.frame_id     = id_pool[k];
        r.length_code  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(6, 8));
        r.byte_index   = 3'($urandom);
        r.timestamp_us = now_us;
        if (sel < 65) begin
            flip = 0;
            for (int b = 0; b < 8; b++)
                if ($urandom_range(0, 3) == 0) flip[8*b +: 8] = 8'($urandom);
            r.payload = last_pay[k] ^ flip;
            last_pay[k] = r.payload;
            case ($urandom_range(0, 19))
                0: now_us = now_us - $urandom_range(1, 5000);
                1: now_us = now_us + {$urandom, $urandom} % 64'h3_0000_0000;
                default: now_us = now_us + $urandom_range(0, 20000);
            endcase
            r.timestamp_us = now_us;
        end else if (sel < 90) begin
            r.req_type = REQ_READ;
            r.payload  = {$urandom, $urandom};
            if ($urandom_range(0, 9) == 0) r.frame_id = 29'($urandom);
        end else begin
            r.req_type     = 1'($urandom);
            r.channel      = 8'($urandom);
            r.frame_id     = ($urandom_range(0, 1) == 0) ? 29'($urandom) : 29'($urandom_range(0, 4095));
            r.length_code  = 4'($urandom);
            r.payload      = {$urandom, $urandom};
            r.timestamp_us = {$urandom, $urandom};
        end
        return r;
    endfunction

    initial begin
        t_request d[$];
        int       sent;
        int       burst;
        int       wait_cycles;
        for (int k = 0; k < 16; k++) last_pay[k] = {$urandom, $urandom};
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: first frame, unchanged and changed bytes, DLC limits, zero period,
        // backwards and huge gaps, dropped IDs, clamped channels, large-ID reads.
        d.push_back('{REQ_READ,   8'd0,   29'd5,          4'd0,  64'd0, 64'd0, 3'd0});
        d.push_back('{REQ_UPDATE, 8'd0,   29'd5,          4'd8,  64'h0807060504030201,
                      64'd100, 3'd0});
        d.push_back('{REQ_UPDATE, 8'd0,   29'd5,          4'd8,  64'h0807060504030201,
                      64'd100, 3'd7});
        d.push_back('{REQ_UPDATE, 8'd0,   29'd5,          4'd15, 64'hFF07060504030201,
                      64'd300, 3'd7});
        d.push_back('{REQ_UPDATE, 8'd0,   29'd5,          4'd3,  64'hAAAAAAAAAA000000,
                      64'd350, 3'd2});
        d.push_back('{REQ_UPDATE, 8'd0,   29'd5,          4'd0,  64'hFFFFFFFFFFFFFFFF,
                      64'd360, 3'd5});
        d.push_back('{REQ_UPDATE, 8'd0,   29'd5,          4'd8,  64'h0, 64'd10, 3'd1});
        d.push_back('{REQ_UPDATE, 8'd0,   29'd5,          4'd8,  64'h0,
                      64'hFFFF_FFFF_FFFF_FFFF, 3'd0});
        d.push_back('{REQ_UPDATE, 8'd0,   29'd5,          4'd8,  64'h1, 64'd0, 3'd0});
        d.push_back('{REQ_UPDATE, 8'd1,   29'd2047,       4'd8,  64'hFFFFFFFFFFFFFFFF,
                      64'hFFFF_FFFF_FFFF_FFFF, 3'd7});
        d.push_back('{REQ_UPDATE, 8'd255, 29'd2047,       4'd1,  64'h0,
                      64'hFFFF_FFFF_FFFF_FFF0, 3'd0});
        d.push_back('{REQ_UPDATE, 8'd2,   29'd0,          4'd8,  64'h0, 64'd0, 3'd0});
        d.push_back('{REQ_UPDATE, 8'd0,   29'd0,          4'd8,  64'h0, 64'd0, 3'd0});
        d.push_back('{REQ_UPDATE, 8'd1,   29'd2048,       4'd8,  64'h55, 64'd5, 3'd0});
        d.push_back('{REQ_UPDATE, 8'd0,   29'h1FFF_FFFF,  4'd8,  64'h55, 64'd5, 3'd0});
        d.push_back('{REQ_READ,   8'd1,   29'h1FFF_FFFF,  4'd0,  64'd0, 64'd0, 3'd7});
        d.push_back('{REQ_READ,   8'd200, 29'd2047,       4'd0,  64'd0, 64'd0, 3'd7});
        d.push_back('{REQ_READ,   8'd0,   29'd5000,       4'd0,  64'd0, 64'd0, 3'd3});
        d.push_back('{REQ_READ,   8'd0,   29'd5,          4'd0,  64'd0, 64'd0, 3'd0});
        d.push_back('{REQ_READ,   8'd1,   29'd2047,       4'd15, 64'd0, 64'd0, 3'd4});
        foreach (d[n]) send_request(d[n]);
        idle_for(1);

        // Random part: bursts of random length with random gaps, some back-to-back runs.
        sent = 0;
        while (sent < RAND_ITEMS) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < RAND_ITEMS; b++) begin
                send_request(random_request());
                sent++;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (wait_cycles > 0) idle_for(wait_cycles);
        end
        i_valid = 1'b0;

        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
        $display("Ran %0d updates, %0d reads and %0d dropped updates; %0d results checked.",
                 sb.updates, sb.reads, sb.drops, sb.results);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
